### src/dplc_pkg.sv
// ----------------------------------------------------------------------------
// dplc_pkg
// Shared types and codes for the distance pulse lubricator controller.
// ----------------------------------------------------------------------------
package dplc_pkg;

  // Register widths
  localparam int ACT_W   = 24;
  localparam int RANGE_W = 16;
  localparam int TIME_W  = 22;
  localparam int TRAV_W  = 25;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ACTIVATE = 3'd0;
  localparam logic [IDX_W-1:0] REG_RANGE_MIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_RANGE_MAX = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_TO = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOST_TO = 3'd4;
  localparam logic [IDX_W-1:0] REG_FB_INTERVAL = 3'd5;

  // Register reset values
  localparam logic [ACT_W-1:0]   ACTIVATE_RST    = 24'd1000000;
  localparam logic [RANGE_W-1:0] RANGE_MIN_RST   = 16'd0;
  localparam logic [RANGE_W-1:0] RANGE_MAX_RST   = 16'd65535;
  localparam logic [TIME_W-1:0]  START_TO_RST    = 22'd300000;
  localparam logic [TIME_W-1:0]  LOST_TO_RST     = 22'd60000;
  localparam logic [TIME_W-1:0]  FB_INTERVAL_RST = 22'd600000;

  // Event kinds (code 3 is unused)
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_DIST = 2'd1;
  localparam logic [1:0] MODE_FIX  = 2'd2;

  // LED modes
  localparam logic [1:0] LED_NOFIX    = 2'd0;
  localparam logic [1:0] LED_FIX      = 2'd1;
  localparam logic [1:0] LED_FALLBACK = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   activate_distance_mm;
    logic [RANGE_W-1:0] range_min_mm;
    logic [RANGE_W-1:0] range_max_mm;
    logic [TIME_W-1:0]  start_timeout_ms;
    logic [TIME_W-1:0]  lost_fix_timeout_ms;
    logic [TIME_W-1:0]  fallback_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [RANGE_W-1:0] range_mm;
    logic               has_fix;
    logic               button_level;
  } item_t;

  // Packed so that the lowest bit is drop_request
  typedef struct packed {
    logic       sample_accepted;
    logic [1:0] led_mode;
    logic       pump_stop;
    logic       pump_start;
    logic       drop_request;
  } result_t;

endpackage

### src/distance_pulse_lubricator_ctrl.sv
// ----------------------------------------------------------------------------
// distance_pulse_lubricator_ctrl
// Chain lubricator controller: distance and timer driven pump drops.
// ----------------------------------------------------------------------------
// Every input request is one event, chosen by s_tuser: a 1 ms tick carrying
// the button level, a travelled-distance sample in millimetres, or a change
// of position fix. Each event gives exactly one result on the master side:
// drop request, pump start/stop on button edges, LED mode after the event,
// and whether a distance sample fell within [range_min_mm, range_max_mm].
// Accepted samples add to a saturating 25-bit total; once it passes
// activate_distance_mm one drop is requested and the distance subtracted
// (the total is cleared if it is still over). Without a fix a no-fix timer
// (start or lost-fix timeout) switches to fallback, which then requests a
// drop every fallback_interval_ms ticks. Throughput is one request per
// clock: an input register feeds a single pass of add/compare logic into
// the result register, and both stages advance together whenever the
// result register is empty or being read. A request waits in the input
// register and its result in the result register, which drives
// m_tvalid. Configuration writes take effect at once and belong only in
// idle periods.
// ----------------------------------------------------------------------------
module distance_pulse_lubricator_ctrl
  import dplc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // slave side
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // [15:0] range_mm, [16] has_fix, [17] button_level
  input  logic [1:0]       s_tuser,   // [1:0] mode
  // master side
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] drop_request, [1] pump_start, [2] pump_stop,
                                      // [4:3] led_mode, [5] sample_accepted
  // configuration write port
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  result_t out_res;
  logic    in_valid;
  logic    out_valid;
  logic    advance;

  // Core takes the held request when the result slot is free or draining
  assign advance = in_valid && (!out_valid || m_tready);

  dplc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dplc_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (in_item)
  );

  dplc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .item      (in_item),
    .m_tready  (m_tready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  // Button press and release cannot come out of the same tick
  a_start_stop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.pump_start && out_res.pump_stop))
    else $error("pump start and stop in one result");

  // Only a distance sample can be marked accepted
  a_accept_dist_only: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_item.mode != MODE_DIST)) |=> !out_res.sample_accepted)
    else $error("non-distance event marked accepted");

  // A timed drop never comes while the fix is shown
  a_tick_drop_nofix: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_item.mode == MODE_TICK))
      |=> !(out_res.drop_request && (out_res.led_mode == LED_FIX)))
    else $error("fallback drop while fix present");

  // A held request leaves the input register only as a new result
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost on advance");

endmodule

### src/dplc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dplc_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module dplc_cfg_regs
  import dplc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.activate_distance_mm <= ACTIVATE_RST;
      cfg.range_min_mm         <= RANGE_MIN_RST;
      cfg.range_max_mm         <= RANGE_MAX_RST;
      cfg.start_timeout_ms     <= START_TO_RST;
      cfg.lost_fix_timeout_ms  <= LOST_TO_RST;
      cfg.fallback_interval_ms <= FB_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACTIVATE:    cfg.activate_distance_mm <= cfg_data[ACT_W-1:0];
        REG_RANGE_MIN:   cfg.range_min_mm         <= cfg_data[RANGE_W-1:0];
        REG_RANGE_MAX:   cfg.range_max_mm         <= cfg_data[RANGE_W-1:0];
        REG_START_TO:    cfg.start_timeout_ms     <= cfg_data[TIME_W-1:0];
        REG_LOST_TO:     cfg.lost_fix_timeout_ms  <= cfg_data[TIME_W-1:0];
        REG_FB_INTERVAL: cfg.fallback_interval_ms <= cfg_data[TIME_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

### src/dplc_in_reg.sv
// ----------------------------------------------------------------------------
// dplc_in_reg
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module dplc_in_reg
  import dplc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        advance,
  output logic        in_valid,
  output item_t       item
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode         <= s_tuser;
      item.range_mm     <= s_tdata[RANGE_W-1:0];
      item.has_fix      <= s_tdata[16];
      item.button_level <= s_tdata[17];
    end
  end

endmodule

### src/dplc_core.sv
// ----------------------------------------------------------------------------
// dplc_core
// Controller state, one-pass event update and the result register.
// ----------------------------------------------------------------------------
module dplc_core
  import dplc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    advance,
  input  item_t   item,
  input  logic    m_tready,
  output logic    out_valid,
  output result_t out_res
);

  logic [TRAV_W-1:0] travelled_mm, travelled_mm_next;
  logic              in_startup, in_startup_next;
  logic              button_latched, button_latched_next;
  logic [TIME_W-1:0] nofix_count, nofix_count_next;
  logic              nofix_enabled, nofix_enabled_next;
  logic              nofix_use_lost_timeout, nofix_use_lost_timeout_next;
  logic [TIME_W-1:0] fallback_count, fallback_count_next;
  logic              fallback_enabled, fallback_enabled_next;
  logic [1:0]        led_state, led_state_next;
  result_t           res_next;

  // Saturating +1 on a timer count
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] c);
    sat_inc = (c != {TIME_W{1'b1}}) ? c + 1'b1 : c;
  endfunction

  logic [TIME_W-1:0] nofix_inc, fb_inc, nofix_period;
  logic              nofix_fired;
  logic [TRAV_W:0]   sum;
  logic [TRAV_W-1:0] sat_sum, act_ext, diff;
  logic              in_range;

  always_comb begin
    travelled_mm_next           = travelled_mm;
    in_startup_next             = in_startup;
    button_latched_next         = button_latched;
    nofix_count_next            = nofix_count;
    nofix_enabled_next          = nofix_enabled;
    nofix_use_lost_timeout_next = nofix_use_lost_timeout;
    fallback_count_next         = fallback_count;
    fallback_enabled_next       = fallback_enabled;
    led_state_next              = led_state;
    res_next                    = '0;

    nofix_inc    = sat_inc(nofix_count);
    fb_inc       = sat_inc(fallback_count);
    nofix_period = nofix_use_lost_timeout ? cfg.lost_fix_timeout_ms : cfg.start_timeout_ms;
    nofix_fired  = 1'b0;

    in_range = (item.range_mm >= cfg.range_min_mm) && (item.range_mm <= cfg.range_max_mm);
    sum      = {1'b0, travelled_mm} + {{(TRAV_W+1-RANGE_W){1'b0}}, item.range_mm};
    sat_sum  = sum[TRAV_W] ? {TRAV_W{1'b1}} : sum[TRAV_W-1:0];
    act_ext  = {{(TRAV_W-ACT_W){1'b0}}, cfg.activate_distance_mm};
    diff     = sat_sum - act_ext;

    case (item.mode)
      MODE_TICK: begin
        res_next.pump_start = !button_latched && item.button_level;
        res_next.pump_stop  = button_latched && !item.button_level;
        button_latched_next = item.button_level;
        if (nofix_enabled) begin
          if (nofix_inc >= nofix_period) begin
            nofix_fired           = 1'b1;
            in_startup_next       = 1'b0;
            led_state_next        = LED_FALLBACK;
            nofix_count_next      = '0;
            nofix_enabled_next    = 1'b0;
            fallback_count_next   = '0;
            fallback_enabled_next = 1'b1;
          end else begin
            nofix_count_next = nofix_inc;
          end
        end
        // fallback timer skips the tick on which it was started
        if (fallback_enabled && !nofix_fired) begin
          if (fb_inc >= cfg.fallback_interval_ms) begin
            fallback_count_next   = '0;
            res_next.drop_request = 1'b1;
          end else begin
            fallback_count_next = fb_inc;
          end
        end
      end
      MODE_DIST: begin
        if (in_range) begin
          res_next.sample_accepted = 1'b1;
          if (act_ext < sat_sum) begin
            res_next.drop_request = 1'b1;
            // still over after one drop: start over
            travelled_mm_next = (act_ext < diff) ? '0 : diff;
          end else begin
            travelled_mm_next = sat_sum;
          end
        end
      end
      MODE_FIX: begin
        if (item.has_fix) begin
          nofix_use_lost_timeout_next = 1'b1;
          led_state_next              = LED_FIX;
          fallback_count_next         = '0;
          nofix_count_next            = '0;
          nofix_enabled_next          = 1'b0;
          fallback_enabled_next       = 1'b0;
        end else if (!in_startup) begin
          led_state_next     = LED_NOFIX;
          nofix_count_next   = '0;
          nofix_enabled_next = 1'b1;
        end
      end
      default: ;  // unused kind, nothing changes
    endcase

    res_next.led_mode = led_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travelled_mm           <= '0;
      in_startup             <= 1'b1;
      button_latched         <= 1'b0;
      nofix_count            <= '0;
      nofix_enabled          <= 1'b1;
      nofix_use_lost_timeout <= 1'b0;
      fallback_count         <= '0;
      fallback_enabled       <= 1'b0;
      led_state              <= LED_NOFIX;
      out_valid              <= 1'b0;
    end else begin
      if (advance) begin
        travelled_mm           <= travelled_mm_next;
        in_startup             <= in_startup_next;
        button_latched         <= button_latched_next;
        nofix_count            <= nofix_count_next;
        nofix_enabled          <= nofix_enabled_next;
        nofix_use_lost_timeout <= nofix_use_lost_timeout_next;
        fallback_count         <= fallback_count_next;
        fallback_enabled       <= fallback_enabled_next;
        led_state              <= led_state_next;
        out_valid              <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distance pulse lubricator controller.
// ----------------------------------------------------------------------------
// A directed table (register writes and events) runs first. Then come
// randomized phases, each with its own register setting. Every accepted input
// request runs through a cycle-free model of the controller. The model's
// result is queued and compared field by field with each result the block
// hands out. Both stream sides stall at random, and twice the receiver holds
// off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import dplc_pkg::*;

  localparam logic [1:0]       MODE_UNUSED = 2'd3;   // event code with no meaning
  localparam logic [IDX_W-1:0] REG_SPARE6  = 3'd6;   // indexes with no register
  localparam logic [IDX_W-1:0] REG_SPARE7  = 3'd7;
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [TRAV_W-1:0] TRAV_MAX   = '1;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_EVENTS = 162;
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 10;     // pipeline is two deep
  localparam int STALL_LIMIT  = 3000;   // cycles with no transfer or register write

  typedef enum {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  val;
    item_t             ev;
    bit                typed;   // result given by hand in the table
    result_t           res;
  } row_t;

  // ---------------------------------------------------------------- DUT pins
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;   // [15:0] range_mm, [16] has_fix, [17] button_level
  logic [1:0]       s_tuser = '0;   // [1:0] mode
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [0] drop, [1] start, [2] stop, [4:3] led, [5] accepted
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  distance_pulse_lubricator_ctrl i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------ controller model
  // Register copy and controller state, kept in step with accepted requests.
  cfg_t lube_cfg = '{ACTIVATE_RST, RANGE_MIN_RST, RANGE_MAX_RST,
                     START_TO_RST, LOST_TO_RST, FB_INTERVAL_RST};
  logic [TRAV_W-1:0] trav_mm     = '0;
  bit                in_startup  = 1'b1;
  bit                btn_latched = 1'b0;
  logic [TIME_W-1:0] nofix_cnt   = '0;
  bit                nofix_on    = 1'b1;
  bit                use_lost_to = 1'b0;
  logic [TIME_W-1:0] fb_cnt      = '0;
  bit                fb_on       = 1'b0;
  logic [1:0]        led         = LED_NOFIX;

  // One tick of a timer: {fired, next count}. Counts saturate; period 0
  // fires on every tick.
  function automatic logic [TIME_W:0] timer_next(logic [TIME_W-1:0] cnt,
                                                 logic [TIME_W-1:0] period);
    logic [TIME_W-1:0] c;
    c = cnt;
    if (c != TIME_MAX) c = c + 1'b1;
    if (c >= period) return {1'b1, {TIME_W{1'b0}}};
    return {1'b0, c};
  endfunction

  function automatic result_t lube_predict(item_t ev);
    result_t           r;
    logic [TIME_W:0]   nxt;
    logic [TRAV_W:0]   sum;
    logic [TRAV_W:0]   act;
    bit                nofix_fired;
    r = '0;
    nofix_fired = 1'b0;
    act = (TRAV_W+1)'(lube_cfg.activate_distance_mm);
    case (ev.mode)
      MODE_TICK: begin
        // button edges are only seen on ticks
        if (!btn_latched && ev.button_level) begin
          r.pump_start = 1'b1;
          btn_latched = 1'b1;
        end
        if (btn_latched && !ev.button_level) begin
          r.pump_stop = 1'b1;
          btn_latched = 1'b0;
        end
        // no-fix timer first; its firing hands over to the fallback timer,
        // which then skips this tick
        if (nofix_on) begin
          nxt = timer_next(nofix_cnt, use_lost_to ? lube_cfg.lost_fix_timeout_ms
                                                  : lube_cfg.start_timeout_ms);
          nofix_cnt = nxt[TIME_W-1:0];
          if (nxt[TIME_W]) begin
            nofix_fired = 1'b1;
            in_startup = 1'b0;
            led = LED_FALLBACK;
            nofix_cnt = '0;
            nofix_on = 1'b0;
            fb_cnt = '0;
            fb_on = 1'b1;
          end
        end
        if (fb_on && !nofix_fired) begin
          nxt = timer_next(fb_cnt, lube_cfg.fallback_interval_ms);
          fb_cnt = nxt[TIME_W-1:0];
          r.drop_request = nxt[TIME_W];
        end
      end
      MODE_DIST: begin
        if (ev.range_mm >= lube_cfg.range_min_mm && ev.range_mm <= lube_cfg.range_max_mm) begin
          r.sample_accepted = 1'b1;
          sum = {1'b0, trav_mm} + (TRAV_W+1)'(ev.range_mm);
          if (sum > (TRAV_W+1)'(TRAV_MAX)) sum = (TRAV_W+1)'(TRAV_MAX);
          // subtract one activation; still over means clear
          if (act < sum) begin
            sum = sum - act;
            if (act < sum) sum = '0;
            r.drop_request = 1'b1;
          end
          trav_mm = sum[TRAV_W-1:0];
        end
      end
      MODE_FIX: begin
        if (ev.has_fix) begin
          use_lost_to = 1'b1;
          led = LED_FIX;
          fb_cnt = '0;
          nofix_cnt = '0;
          nofix_on = 1'b0;
          fb_on = 1'b0;
        end else if (!in_startup) begin
          // loss of fix before the first fallback is ignored
          led = LED_NOFIX;
          nofix_cnt = '0;
          nofix_on = 1'b1;
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    r.led_mode = led;
    return r;
  endfunction

  // ------------------------------------------------------ monitor and check
  result_t pending_results[$];
  bit      tag_typed = 1'b0;       // travels with the request on the bus
  result_t tag_result = '0;
  int      errors = 0;
  int      events_sent = 0;
  int      results_seen = 0;
  int      drops_seen = 0;
  int      fallback_seen = 0;
  int      starts_seen = 0;
  int      rejects_seen = 0;
  int      writes_done = 0;

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t ev_res;
    result_t want;
    result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[5:0]);
        results_seen++;
        if (got.drop_request) drops_seen++;
        if (got.led_mode == LED_FALLBACK) fallback_seen++;
        if (got.pump_start) starts_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual 0x%02h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("drop_request", want.drop_request, got.drop_request);
          check_field("pump_start", want.pump_start, got.pump_start);
          check_field("pump_stop", want.pump_stop, got.pump_stop);
          check_field("led_mode", want.led_mode, got.led_mode);
          check_field("sample_accepted", want.sample_accepted, got.sample_accepted);
        end
      end
      if (s_tvalid && s_tready) begin
        ev_res = lube_predict(item_t'({s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[17]}));
        if (s_tuser == MODE_DIST && !ev_res.sample_accepted) rejects_seen++;
        pending_results.push_back(tag_typed ? tag_result : ev_res);
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    int stall_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rst)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------ idle pattern
  bit tx_calm = 1'b0;   // phases with no idling on a side
  bit rx_calm = 1'b0;

  // mostly short gaps, a few long ones
  function automatic int draw_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Receiver: random stalls, plus two long hold-offs taken while the sender
  // is offering, so the block fills up and drops s_tready.
  initial begin
    int hold_at;
    int holds_left;
    int gap;
    hold_at = 500;
    holds_left = 2;
    while (rst) @(posedge clk);
    forever begin
      if (holds_left > 0 && results_seen >= hold_at && s_tvalid) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_left--;
        hold_at += 900;
      end else begin
        gap = draw_gap(rx_calm);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------ sender side
  // Offer one request after an optional gap; returns at the accepting edge
  // with s_tvalid still high.
  task automatic send_event(item_t ev, bit typed, result_t res, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser    <= ev.mode;
    s_tdata    <= {6'b0, ev.button_level, ev.has_fix, ev.range_mm};
    tag_typed  <= typed;
    tag_result <= res;
    s_tvalid   <= 1'b1;
    events_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  // Register write, only once every result is back and the block is quiet.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    writes_done++;
    case (idx)
      REG_ACTIVATE:    lube_cfg.activate_distance_mm = val[ACT_W-1:0];
      REG_RANGE_MIN:   lube_cfg.range_min_mm = val[RANGE_W-1:0];
      REG_RANGE_MAX:   lube_cfg.range_max_mm = val[RANGE_W-1:0];
      REG_START_TO:    lube_cfg.start_timeout_ms = val[TIME_W-1:0];
      REG_LOST_TO:     lube_cfg.lost_fix_timeout_ms = val[TIME_W-1:0];
      REG_FB_INTERVAL: lube_cfg.fallback_interval_ms = val[TIME_W-1:0];
      default: ;  // no register there
    endcase
  endtask

  function automatic row_t wr_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    return '{ROW_WRITE, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic row_t ev_row(logic [1:0] mode, logic [15:0] rng, bit fix, bit btn,
                                  bit typed, result_t res);
    item_t ev;
    ev = '{mode: mode, range_mm: rng, has_fix: fix, button_level: btn};
    return '{ROW_EVENT, '0, '0, ev, typed, res};
  endfunction

  function automatic result_t res_of(bit drop, bit start, bit stop, logic [1:0] ledm,
                                     bit acc);
    return '{sample_accepted: acc, led_mode: ledm, pump_stop: stop,
             pump_start: start, drop_request: drop};
  endfunction

  // Random timer period: mostly short so timers fire, sometimes 0 or max.
  // Bits above the register are junk and must be dropped.
  function automatic logic [CFG_W-1:0] draw_period();
    logic [TIME_W-1:0] p;
    logic [1:0]        junk;
    junk = 2'($urandom);
    case ($urandom_range(0, 7))
      0:       p = '0;
      6:       p = TIME_W'($urandom_range(13, 300));
      7:       p = TIME_MAX;
      default: p = TIME_W'($urandom_range(1, 12));
    endcase
    return {junk, p};
  endfunction

  function automatic logic [CFG_W-1:0] draw_activate();
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return 24'd0;   // any nonzero total gives a drop
      5:       return CFG_W'($urandom_range(1, 24'hFFFFFF));
      default: return CFG_W'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_bound(bit upper);
    logic [RANGE_W-1:0] b;
    logic [7:0]         junk;
    junk = 8'($urandom);
    case ($urandom_range(0, 5))
      0, 1:    b = upper ? 16'hFFFF : 16'h0000;
      2:       b = upper ? 16'($urandom_range(30000, 65535)) : 16'($urandom_range(0, 2000));
      3:       b = 16'($urandom);
      4:       b = upper ? 16'h0000 : 16'hFFFF;   // empty or one-point range
      default: b = upper ? 16'($urandom_range(50000, 65535)) : 16'($urandom_range(0, 300));
    endcase
    return {junk, b};
  endfunction

  // Random event: mostly ticks and samples, some fix changes, rare junk.
  // Fields the event does not use carry random bits.
  bit btn_level = 1'b0;

  function automatic item_t draw_event();
    item_t ev;
    int    r;
    ev.range_mm = 16'($urandom);
    ev.has_fix = 1'($urandom);
    ev.button_level = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      ev.mode = MODE_TICK;
      if ($urandom_range(0, 3) == 0) btn_level = ~btn_level;
      ev.button_level = btn_level;
    end else if (r < 85) begin
      ev.mode = MODE_DIST;
      case ($urandom_range(0, 9))
        3:       ev.range_mm = lube_cfg.range_min_mm;
        4:       ev.range_mm = lube_cfg.range_min_mm - 1'b1;
        5:       ev.range_mm = lube_cfg.range_max_mm;
        6:       ev.range_mm = lube_cfg.range_max_mm + 1'b1;
        7:       ev.range_mm = 16'($urandom_range(0, 255));
        8:       ev.range_mm = 16'hFFFF;
        9:       ev.range_mm = 16'h0000;
        default: ;
      endcase
    end else if (r < 97) begin
      ev.mode = MODE_FIX;
      ev.has_fix = ($urandom_range(0, 99) < 35);
    end else begin
      ev.mode = MODE_UNUSED;
    end
    return ev;
  endfunction

  // ------------------------------------------------------ main sequence
  initial begin
    row_t dir_rows[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Typed results follow from reset state at a glance;
    // the rest go through the model.
    dir_rows.push_back(wr_row(REG_START_TO, 24'd3));
    dir_rows.push_back(wr_row(REG_FB_INTERVAL, 24'd0));   // zero period
    dir_rows.push_back(wr_row(REG_ACTIVATE, 24'd0));      // zero activation
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 0, 1, res_of(0, 0, 0, LED_NOFIX, 0)));
    dir_rows.push_back(ev_row(MODE_DIST, 16'h0000, 0, 0, 1, res_of(0, 0, 0, LED_NOFIX, 1)));
    dir_rows.push_back(ev_row(MODE_DIST, 16'hFFFF, 0, 0, 1, res_of(1, 0, 0, LED_NOFIX, 1)));
    // fix loss during startup is ignored; unused code does nothing
    dir_rows.push_back(ev_row(MODE_FIX, 16'h0000, 0, 0, 1, res_of(0, 0, 0, LED_NOFIX, 0)));
    dir_rows.push_back(ev_row(MODE_UNUSED, 16'hFFFF, 1, 1, 1, res_of(0, 0, 0, LED_NOFIX, 0)));
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 1, 1, res_of(0, 1, 0, LED_NOFIX, 0)));
    // start timeout expires, then zero-period fallback drops
    dir_rows.push_back(ev_row(MODE_TICK, 16'hFFFF, 1, 1, 0, '0));
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_TICK, 16'hFFFF, 1, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_FIX, 16'h0000, 1, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 1, 0, '0));
    dir_rows.push_back(ev_row(MODE_FIX, 16'hFFFF, 0, 1, 0, '0));
    dir_rows.push_back(wr_row(REG_LOST_TO, 24'd1));
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 0, 0, '0));
    // range edges
    dir_rows.push_back(wr_row(REG_ACTIVATE, 24'hFFFFFF));
    dir_rows.push_back(wr_row(REG_RANGE_MIN, 24'd100));
    dir_rows.push_back(wr_row(REG_RANGE_MAX, 24'd200));
    dir_rows.push_back(ev_row(MODE_DIST, 16'd99, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'd100, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'd200, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'd201, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'hFFFF, 0, 0, 0, '0));
    // total still over after the subtraction: cleared
    dir_rows.push_back(wr_row(REG_ACTIVATE, 24'd150));
    dir_rows.push_back(wr_row(REG_RANGE_MIN, 24'd0));
    dir_rows.push_back(wr_row(REG_RANGE_MAX, 24'd65535));
    dir_rows.push_back(ev_row(MODE_DIST, 16'hFFFF, 0, 0, 0, '0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'd151, 0, 0, 0, '0));
    // empty range, and writes to indexes with no register
    dir_rows.push_back(wr_row(REG_RANGE_MIN, 24'd65535));
    dir_rows.push_back(wr_row(REG_RANGE_MAX, 24'd0));
    dir_rows.push_back(ev_row(MODE_DIST, 16'h0000, 0, 0, 0, '0));
    dir_rows.push_back(wr_row(REG_SPARE6, 24'hFFFFFF));
    dir_rows.push_back(wr_row(REG_SPARE7, 24'hFFFFFF));
    dir_rows.push_back(ev_row(MODE_DIST, 16'hFFFF, 0, 0, 0, '0));
    // timer maxima
    dir_rows.push_back(wr_row(REG_RANGE_MIN, 24'd0));
    dir_rows.push_back(wr_row(REG_RANGE_MAX, 24'd65535));
    dir_rows.push_back(wr_row(REG_START_TO, 24'hFFFFFF));
    dir_rows.push_back(wr_row(REG_LOST_TO, 24'hFFFFFF));
    dir_rows.push_back(wr_row(REG_FB_INTERVAL, 24'hFFFFFF));
    dir_rows.push_back(ev_row(MODE_TICK, 16'hFFFF, 1, 1, 0, '0));
    dir_rows.push_back(ev_row(MODE_TICK, 16'h0000, 0, 0, 0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      else
        send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res, draw_gap(1'b0));
    end

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_ACTIVATE, draw_activate());
      write_reg(REG_RANGE_MIN, draw_bound(1'b0));
      write_reg(REG_RANGE_MAX, draw_bound(1'b1));
      write_reg(REG_START_TO, draw_period());
      write_reg(REG_LOST_TO, draw_period());
      write_reg(REG_FB_INTERVAL, draw_period());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_EVENTS; n++)
        send_event(draw_event(), 1'b0, '0, draw_gap(tx_calm));
    end

    // Drain, then give the block time to show any extra result.
    s_tvalid <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b1;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("summary: %0d events, %0d results, %0d register writes, %0d mismatches",
             events_sent, results_seen, writes_done, errors);
    $display("summary: %0d drops, %0d in fallback, %0d pump starts, %0d samples rejected",
             drops_seen, fallback_seen, starts_seen, rejects_seen);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
src/dplc_pkg.sv
src/dplc_cfg_regs.sv
src/dplc_in_reg.sv
src/dplc_core.sv
src/distance_pulse_lubricator_ctrl.sv
dv/tb_top.sv
